### rtl/core/assert_macros.svh
// Assertion macros used by the checker file of the frame receiver.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define FRC7_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("frame receiver assertion failed");

// Clocked assertion that is also checked while reset is asserted.
`define FRC7_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk_i) (prop)) \
    else $error("frame receiver reset assertion failed");

`endif

### rtl/core/frc7_pkg.sv
// Package with the types and constants of the CRC-7 checked frame receiver.
`timescale 1ns / 1ps
`default_nettype none

package frc7_pkg;

  localparam logic [7:0] CrcDivisorReset = 8'hA7;

  typedef enum logic [6:0] {
    PH_ID_HI = 7'b0000001,
    PH_ID_LO = 7'b0000010,
    PH_FUNC  = 7'b0000100,
    PH_LEN   = 7'b0001000,
    PH_BASE  = 7'b0010000,
    PH_DATA  = 7'b0100000,
    PH_CHECK = 7'b1000000
  } frc7_phase_e;

  typedef enum logic {
    KIND_DATA    = 1'b0,
    KIND_SUMMARY = 1'b1
  } frc7_kind_e;

  typedef struct packed {
    frc7_kind_e  item_kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [15:0] sender_id;
    logic [7:0]  func_code;
    logic [7:0]  payload_length;
    logic [7:0]  start_address;
    logic        crc_ok;
  } frc7_item_t;

  typedef struct packed {
    logic       emit;
    frc7_item_t item;
  } frc7_result_t;

endpackage

`default_nettype wire

### rtl/core/frc7_rx_if.sv
// Interface of the received byte channel.
`timescale 1ns / 1ps
`default_nettype none

interface frc7_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### rtl/core/frc7_item_if.sv
// Interface of the result item channel.
`timescale 1ns / 1ps
`default_nettype none

interface frc7_item_if;
  logic        valid;
  logic        ready;
  logic        item_kind;
  logic [7:0]  payload_byte;
  logic [7:0]  payload_index;
  logic [15:0] sender_id;
  logic [7:0]  func_code;
  logic [7:0]  payload_length;
  logic [7:0]  start_address;
  logic        crc_ok;

  modport source (
    output valid, output item_kind, output payload_byte, output payload_index,
    output sender_id, output func_code, output payload_length,
    output start_address, output crc_ok, input ready
  );
  modport sink (
    input valid, input item_kind, input payload_byte, input payload_index,
    input sender_id, input func_code, input payload_length,
    input start_address, input crc_ok, output ready
  );
endinterface

`default_nettype wire

### rtl/core/frame_receiver_crc7_check_core.sv
// Top level of the CRC-7 checked frame receiver.
//
// Received bytes arrive on rx_i, a valid/ready channel; a transfer takes one
// byte. Results leave on item_o: one data item for each payload byte and one
// summary item with the CRC-ok flag for each check byte. Header bytes give
// no result. The user must write the CRC divisor through crc_divisor_we_i
// and crc_divisor_i while no frame byte is in flight, which is not enforced.
//
// A byte waits in the input register, then the parse step and the CRC update
// run combinationally into the output register, from which its result is
// shown on item_o. One byte per cycle is taken without gaps as long as item_o
// is taken.
//
// Reset empties both registers, clears the parse state and loads the divisor
// with 0xA7. When item_o stalls, the result holds and the byte behind it
// waits in the input register; rx_i.ready drops only when both are full.
`timescale 1ns / 1ps
`default_nettype none

module frame_receiver_crc7_check_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       crc_divisor_we_i,
  input  logic [7:0] crc_divisor_i,
  frc7_rx_if.sink    rx_i,
  frc7_item_if.source item_o
);
  import frc7_pkg::*;

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         out_valid_q;
  frc7_item_t   out_item_q;
  logic [7:0]   divisor_q;
  frc7_result_t result;
  logic         out_free;
  logic         advance;

  assign out_free   = !out_valid_q || item_o.ready;
  assign advance    = in_valid_q && (!result.emit || out_free);
  assign rx_i.ready = !in_valid_q || advance;

  frc7_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .byte_i    (in_byte_q),
    .divisor_i (divisor_q),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      divisor_q <= CrcDivisorReset;
    end else if (crc_divisor_we_i) begin
      divisor_q <= crc_divisor_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.ready && rx_i.valid) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && result.emit) begin
      out_valid_q <= 1'b1;
    end else if (item_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && result.emit) begin
      out_item_q <= result.item;
    end
  end

  assign item_o.valid          = out_valid_q;
  assign item_o.item_kind      = out_item_q.item_kind;
  assign item_o.payload_byte   = out_item_q.payload_byte;
  assign item_o.payload_index  = out_item_q.payload_index;
  assign item_o.sender_id      = out_item_q.sender_id;
  assign item_o.func_code      = out_item_q.func_code;
  assign item_o.payload_length = out_item_q.payload_length;
  assign item_o.start_address  = out_item_q.start_address;
  assign item_o.crc_ok         = out_item_q.crc_ok;

endmodule

`default_nettype wire

### rtl/core/frc7_crc.sv
// Byte-wide MSB-first CRC-7 remainder update.
`timescale 1ns / 1ps
`default_nettype none

module frc7_crc (
  input  logic [6:0] rem_i,
  input  logic [7:0] byte_i,
  input  logic [6:0] taps_i,
  output logic [6:0] rem_o
);

  always_comb begin
    logic [6:0] rem;
    logic       fb;
    rem = rem_i;
    for (int b = 7; b >= 0; b--) begin
      fb  = rem[6] ^ byte_i[b];
      rem = {rem[5:0], 1'b0};
      if (fb) begin
        rem = rem ^ taps_i;
      end
    end
    rem_o = rem;
  end

endmodule

`default_nettype wire

### rtl/core/frc7_parser.sv
// Frame parse state and the per-byte parse step.
`timescale 1ns / 1ps
`default_nettype none

module frc7_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          byte_i,
  input  logic [7:0]          divisor_i,
  output frc7_pkg::frc7_result_t result_o
);
  import frc7_pkg::*;

  frc7_phase_e phase_q, phase_d;
  logic [7:0]  count_q, count_d;
  logic [6:0]  rem_q, rem_d;
  logic [15:0] id_q, id_d;
  logic [7:0]  func_q, func_d;
  logic [7:0]  len_q, len_d;
  logic [7:0]  base_q, base_d;
  logic [6:0]  crc_in;
  logic [6:0]  crc_out;
  logic [7:0]  count_inc;

  assign crc_in    = (phase_q == PH_DATA || phase_q == PH_ID_LO || phase_q == PH_FUNC ||
                      phase_q == PH_LEN || phase_q == PH_BASE) ? rem_q : 7'd0;
  assign count_inc = count_q + 8'd1;

  frc7_crc u_crc (
    .rem_i  (crc_in),
    .byte_i (byte_i),
    .taps_i (divisor_i[6:0]),
    .rem_o  (crc_out)
  );

  always_comb begin
    phase_d  = phase_q;
    count_d  = count_q;
    rem_d    = crc_out;
    id_d     = id_q;
    func_d   = func_q;
    len_d    = len_q;
    base_d   = base_q;
    result_o = '0;
    result_o.item.sender_id      = id_q;
    result_o.item.func_code      = func_q;
    result_o.item.payload_length = len_q;
    result_o.item.start_address  = base_q;
    unique case (phase_q)
      PH_ID_LO: begin
        id_d    = {id_q[15:8], byte_i};
        phase_d = PH_FUNC;
      end
      PH_FUNC: begin
        func_d  = byte_i;
        phase_d = PH_LEN;
      end
      PH_LEN: begin
        len_d   = byte_i;
        phase_d = PH_BASE;
      end
      PH_BASE: begin
        base_d  = byte_i;
        count_d = 8'd0;
        phase_d = (len_q == 8'd0) ? PH_CHECK : PH_DATA;
      end
      PH_DATA: begin
        result_o.emit               = 1'b1;
        result_o.item.item_kind     = KIND_DATA;
        result_o.item.payload_byte  = byte_i;
        result_o.item.payload_index = count_q;
        count_d                     = count_inc;
        if (count_inc == len_q) begin
          phase_d = PH_CHECK;
        end
      end
      PH_CHECK: begin
        result_o.emit           = 1'b1;
        result_o.item.item_kind = KIND_SUMMARY;
        result_o.item.crc_ok    = (byte_i[6:0] == rem_q);
        rem_d                   = 7'd0;
        count_d                 = 8'd0;
        phase_d                 = PH_ID_HI;
      end
      default: begin
        id_d    = {byte_i, 8'd0};
        count_d = 8'd0;
        phase_d = PH_ID_LO;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ID_HI;
      count_q <= 8'd0;
      rem_q   <= 7'd0;
      id_q    <= 16'd0;
      func_q  <= 8'd0;
      len_q   <= 8'd0;
      base_q  <= 8'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      count_q <= count_d;
      rem_q   <= rem_d;
      id_q    <= id_d;
      func_q  <= func_d;
      len_q   <= len_d;
      base_q  <= base_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/frc7_checker.sv
// Port-level checks of the frame receiver and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module frc7_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        item_valid_i,
  input logic        item_ready_i,
  input logic        item_kind_i,
  input logic [7:0]  payload_byte_i,
  input logic [7:0]  payload_index_i,
  input logic [7:0]  payload_length_i,
  input logic        crc_ok_i
);
  import frc7_pkg::*;

  logic data_shown;
  logic summary_shown;

  assign data_shown    = item_valid_i && item_kind_i == KIND_DATA;
  assign summary_shown = item_valid_i && item_kind_i == KIND_SUMMARY;

  `FRC7_ASSERT_RST(a_reset_no_item, !rst_ni |=> !item_valid_i)
  `FRC7_ASSERT(a_item_held, item_valid_i && !item_ready_i |=> item_valid_i)
  `FRC7_ASSERT(a_data_index, data_shown |-> payload_index_i < payload_length_i && !crc_ok_i)
  `FRC7_ASSERT(a_summary_clear, summary_shown |-> (payload_byte_i | payload_index_i) == 8'd0)

endmodule

bind frame_receiver_crc7_check_core frc7_checker u_frc7_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .item_valid_i     (item_o.valid),
  .item_ready_i     (item_o.ready),
  .item_kind_i      (item_o.item_kind),
  .payload_byte_i   (item_o.payload_byte),
  .payload_index_i  (item_o.payload_index),
  .payload_length_i (item_o.payload_length),
  .crc_ok_i         (item_o.crc_ok)
);

`default_nettype wire

### tb/sv/frame_receiver_crc7_check_core_test.sv
// Self-checking testbench for the CRC-7 checked frame receiver core.
`timescale 1ns / 1ps

import frc7_pkg::*;

typedef logic [7:0] byte_q_t[$];

class frc7_scoreboard;
  logic [7:0]  divisor;
  frc7_phase_e phase;
  logic [7:0]  data_count;
  logic [6:0]  remainder;
  logic [15:0] node_id;
  logic [7:0]  func;
  logic [7:0]  length;
  logic [7:0]  base;
  frc7_item_t  expected_q[$];
  int          errors;
  int          bytes_taken;
  int          data_seen;
  int          summaries_seen;
  int          crc_ok_seen;

  function new();
    divisor = CrcDivisorReset;
    phase = PH_ID_HI;
    data_count = '0;
    remainder = '0;
    node_id = '0;
    func = '0;
    length = '0;
    base = '0;
  endfunction

  static function logic [6:0] crc7_feed(logic [6:0] rem, logic [7:0] b, logic [7:0] div);
    logic fb;
    for (int i = 7; i >= 0; i--) begin
      fb = rem[6] ^ b[i];
      rem = {rem[5:0], 1'b0};
      if (fb) rem = rem ^ div[6:0];
    end
    return rem;
  endfunction

  function void set_divisor(logic [7:0] d);
    divisor = d;
  endfunction

  function int pending();
    return expected_q.size();
  endfunction

  function frc7_item_t item_of(frc7_kind_e kind, logic [7:0] pbyte, logic [7:0] pidx,
                               logic ok);
    frc7_item_t it;
    it.item_kind = kind;
    it.payload_byte = pbyte;
    it.payload_index = pidx;
    it.sender_id = node_id;
    it.func_code = func;
    it.payload_length = length;
    it.start_address = base;
    it.crc_ok = ok;
    return it;
  endfunction

  // Advances the parser by one received byte and queues any item it causes.
  function void note_rx(logic [7:0] b);
    bytes_taken++;
    case (phase)
      PH_ID_LO: begin
        node_id[7:0] = b;
        remainder = crc7_feed(remainder, b, divisor);
        phase = PH_FUNC;
      end
      PH_FUNC: begin
        func = b;
        remainder = crc7_feed(remainder, b, divisor);
        phase = PH_LEN;
      end
      PH_LEN: begin
        length = b;
        remainder = crc7_feed(remainder, b, divisor);
        phase = PH_BASE;
      end
      PH_BASE: begin
        base = b;
        remainder = crc7_feed(remainder, b, divisor);
        data_count = '0;
        phase = (length == 8'd0) ? PH_CHECK : PH_DATA;
      end
      PH_DATA: begin
        expected_q.push_back(item_of(KIND_DATA, b, data_count, 1'b0));
        remainder = crc7_feed(remainder, b, divisor);
        data_count = data_count + 8'd1;
        if (data_count == length) phase = PH_CHECK;
      end
      PH_CHECK: begin
        expected_q.push_back(item_of(KIND_SUMMARY, 8'h00, 8'h00, b[6:0] == remainder));
        remainder = '0;
        data_count = '0;
        phase = PH_ID_HI;
      end
      default: begin
        node_id = {b, 8'h00};
        remainder = crc7_feed(7'd0, b, divisor);
        data_count = '0;
        phase = PH_ID_LO;
      end
    endcase
  endfunction

  task report(string msg);
    errors++;
    if (errors <= 40) $display("MISMATCH: %s", msg);
  endtask

  task check_item(frc7_item_t got);
    frc7_item_t want;
    string diffs;
    if (expected_q.size() == 0) begin
      report($sformatf("item with no transfer pending: kind %0d byte %02h index %0d",
                       got.item_kind, got.payload_byte, got.payload_index));
      return;
    end
    want = expected_q.pop_front();
    diffs = "";
    if (got.item_kind !== want.item_kind)
      diffs = {diffs, $sformatf(" kind %0d/%0d", got.item_kind, want.item_kind)};
    if (got.payload_byte !== want.payload_byte)
      diffs = {diffs, $sformatf(" byte %02h/%02h", got.payload_byte, want.payload_byte)};
    if (got.payload_index !== want.payload_index)
      diffs = {diffs, $sformatf(" index %0d/%0d", got.payload_index, want.payload_index)};
    if (got.sender_id !== want.sender_id)
      diffs = {diffs, $sformatf(" id %04h/%04h", got.sender_id, want.sender_id)};
    if (got.func_code !== want.func_code)
      diffs = {diffs, $sformatf(" func %02h/%02h", got.func_code, want.func_code)};
    if (got.payload_length !== want.payload_length)
      diffs = {diffs, $sformatf(" len %0d/%0d", got.payload_length, want.payload_length)};
    if (got.start_address !== want.start_address)
      diffs = {diffs, $sformatf(" base %02h/%02h", got.start_address, want.start_address)};
    if (got.crc_ok !== want.crc_ok)
      diffs = {diffs, $sformatf(" crc_ok %0d/%0d", got.crc_ok, want.crc_ok)};
    if (diffs != "") report({"item differs (got/expected):", diffs});
    if (want.item_kind == KIND_SUMMARY) begin
      summaries_seen++;
      if (want.crc_ok) crc_ok_seen++;
    end else begin
      data_seen++;
    end
  endtask

  task finish_check();
    frc7_item_t want;
    while (expected_q.size() != 0) begin
      want = expected_q.pop_front();
      report($sformatf("expected item never arrived: kind %0d byte %02h index %0d",
                       want.item_kind, want.payload_byte, want.payload_index));
    end
  endtask
endclass

module frame_receiver_crc7_check_core_test;

  typedef enum logic [1:0] {
    SINK_OPEN,
    SINK_COIN,
    SINK_BEAT,
    SINK_RARE
  } sink_mode_e;

  localparam int RandomBytes = 1950;
  localparam int NumSettings = 8;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we = 1'b0;
  logic [7:0] cfg_data = 8'h00;
  logic       rx_valid = 1'b0;
  logic [7:0] rx_data = 8'h00;
  logic       sink_ready = 1'b0;

  sink_mode_e sink_mode = SINK_OPEN;
  int         sink_left = 0;
  int         sink_tick = 0;
  int         burst_left = 0;

  frc7_scoreboard board;

  frc7_rx_if   rx_ch ();
  frc7_item_if item_ch ();

  assign rx_ch.valid = rx_valid;
  assign rx_ch.rx_byte = rx_data;
  assign item_ch.ready = sink_ready;

  frame_receiver_crc7_check_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .crc_divisor_we_i(cfg_we),
    .crc_divisor_i   (cfg_data),
    .rx_i            (rx_ch),
    .item_o          (item_ch)
  );

  always #1 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    if (sink_left == 0) begin
      sink_mode = sink_mode_e'($urandom_range(0, 3));
      sink_left = $urandom_range(10, 150);
    end
    sink_left--;
    sink_tick++;
    case (sink_mode)
      SINK_OPEN: sink_ready <= 1'b1;
      SINK_COIN: sink_ready <= 1'($urandom_range(0, 1));
      SINK_BEAT: sink_ready <= (sink_tick % 5) >= 2;
      default: sink_ready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk_i) begin : watch_items
    frc7_item_t got;
    if (rst_ni && item_ch.valid && item_ch.ready) begin
      got.item_kind = frc7_kind_e'(item_ch.item_kind);
      got.payload_byte = item_ch.payload_byte;
      got.payload_index = item_ch.payload_index;
      got.sender_id = item_ch.sender_id;
      got.func_code = item_ch.func_code;
      got.payload_length = item_ch.payload_length;
      got.start_address = item_ch.start_address;
      got.crc_ok = item_ch.crc_ok;
      board.check_item(got);
    end
  end

  // Driver tasks are entered and left just after a falling edge.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(1, 12);
      rx_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 300)
                                               : $urandom_range(1, 16);
    end
    rx_valid <= 1'b1;
    rx_data <= b;
    do @(posedge clk_i); while (!rx_ch.ready);
    board.note_rx(b);
    burst_left--;
    @(negedge clk_i);
  endtask

  task automatic send_frame(input logic [15:0] node_id, input logic [7:0] func,
                            input logic [7:0] base, input byte_q_t body,
                            input logic good, input logic top_bit);
    byte_q_t frame;
    logic [6:0] rem;
    frame.push_back(node_id[15:8]);
    frame.push_back(node_id[7:0]);
    frame.push_back(func);
    frame.push_back(8'(body.size()));
    frame.push_back(base);
    foreach (body[i]) frame.push_back(body[i]);
    rem = '0;
    foreach (frame[i]) rem = board.crc7_feed(rem, frame[i], board.divisor);
    if (!good) rem = rem ^ 7'($urandom_range(1, 127));
    frame.push_back({top_bit, rem});
    foreach (frame[i]) send_byte(frame[i]);
  endtask

  task automatic write_divisor(input logic [7:0] d);
    rx_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_data <= d;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    board.set_divisor(d);
  endtask

  task automatic random_frame(input int len);
    byte_q_t body;
    repeat (len) body.push_back(8'($urandom));
    send_frame(16'($urandom), 8'($urandom), 8'($urandom), body,
               $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)));
  endtask

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    byte_q_t body;
    logic [7:0] plan [NumSettings];
    int goal;
    int directed;
    int pick;
    board = new();
    plan[0] = 8'h80;
    plan[1] = 8'hFF;
    plan[2] = 8'h00;
    plan[3] = 8'h7F;
    plan[4] = 8'($urandom_range(128, 255));
    plan[5] = 8'($urandom_range(0, 255));
    plan[6] = CrcDivisorReset;
    plan[7] = 8'($urandom_range(128, 255));

    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Empty payload with an all-ones id, function code and base, and the check byte's top bit set.
    send_frame(16'hFFFF, 8'hFF, 8'hFF, body, 1'b1, 1'b1);
    body = '{8'h00, 8'hFF};
    send_frame(16'h0000, 8'h00, 8'h00, body, 1'b0, 1'b0);
    body = '{8'hA5};
    send_frame(16'h8001, 8'h5A, 8'h80, body, 1'b1, 1'b0);
    directed = board.bytes_taken;

    for (int p = 0; p < NumSettings; p++) begin
      // Now and then the divisor changes in the middle of a frame.
      if (p > 0 && $urandom_range(0, 1) == 1)
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      write_divisor(plan[p]);
      if (p == 2) random_frame(255);
      goal = directed + (p + 1) * RandomBytes / NumSettings;
      while (board.bytes_taken < goal) begin
        pick = $urandom_range(0, 99);
        if (pick < 8)
          repeat ($urandom_range(1, 5)) send_byte(8'($urandom));
        else if (pick < 10)
          random_frame($urandom_range(32, 255));
        else
          random_frame($urandom_range(0, 10));
      end
    end

    rx_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    board.finish_check();

    $display("Run covered %0d received bytes, %0d payload items and %0d frame summaries",
             board.bytes_taken, board.data_seen, board.summaries_seen);
    $display("(%0d with a matching check byte) over %0d divisor settings.",
             board.crc_ok_seen, NumSettings + 1);
    if (board.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
